@@ src/e2q_pkg.sv @@
// ----------------------------------------------------------------------------
// e2q_pkg: shared types and constants
// Payload structs, CORDIC arctangent table and fixed-point constants.
// ----------------------------------------------------------------------------
package e2q_pkg;

   localparam int CordicSteps = 24;
   localparam logic signed [27:0] CordicGainQ24 = 28'sd10188014;
   localparam logic signed [16:0] HalfPiQ14 = 17'sd25736;
   localparam logic signed [16:0] PiQ14 = 17'sd51472;
   localparam logic signed [15:0] Q14One = 16'sd16384;

   typedef struct packed {
      logic signed [15:0] yaw_angle;
      logic signed [15:0] pitch_angle;
      logic signed [15:0] roll_angle;
   } req_type;

   typedef struct packed {
      logic signed [15:0] quat_w;
      logic signed [15:0] quat_x;
      logic signed [15:0] quat_y;
      logic signed [15:0] quat_z;
   } rsp_type;

   function automatic logic signed [27:0] atan_q24(input logic [4:0] idx);
      logic signed [27:0] r;
      case (idx)
         5'd0: r = 28'sd13176795;
         5'd1: r = 28'sd7778716;
         5'd2: r = 28'sd4110060;
         5'd3: r = 28'sd2086331;
         5'd4: r = 28'sd1047214;
         5'd5: r = 28'sd524117;
         5'd6: r = 28'sd262123;
         5'd7: r = 28'sd131069;
         default: r = 28'sd1 <<< (5'd24 - idx);
      endcase
      return r;
   endfunction

endpackage

@@ src/euler_to_quaternion.sv @@
// ----------------------------------------------------------------------------
// euler_to_quaternion: Z-Y-X Euler angles to unit quaternion
// Pipelined CORDIC half-angle trigonometry followed by triple products.
// ----------------------------------------------------------------------------
// Usage: an orientation (yaw, pitch, roll, radians times 8192) is offered on
// the req_ channel; a transfer occurs on a clock edge where req_valid is high
// and req_stall is low. The quaternion leaves on the rsp_ channel as Q1.14,
// each component saturated to plus or minus one.
// The datapath is one pipeline of 29 register stages: one fold stage, 24
// CORDIC iteration stages (one rotation each, three angles in parallel),
// one rounding stage, two product stages and the output register, which
// takes the rounded and saturated sums. A new transfer may be accepted in
// every cycle in which no stalled result blocks the output.
// When the receiver stalls, the whole pipeline holds, so nothing is lost or
// repeated; req_stall simply follows rsp_stall while a result is waiting.
// Synchronous reset clears every valid bit; payload registers are not reset.
// ----------------------------------------------------------------------------
module euler_to_quaternion #(
   parameter int Steps = e2q_pkg::CordicSteps
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  e2q_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output e2q_pkg::rsp_type  rsp_data
);

   // A stage advances whenever the output is free or the output is empty.
   logic adv;
   assign adv = !(rsp_valid && rsp_stall);
   assign req_stall = !adv;

   // CORDIC stage registers; entry 0 is loaded by the fold stage.
   logic signed [27:0] cx_ff [Steps+1][3];
   logic signed [27:0] cy_ff [Steps+1][3];
   logic signed [27:0] cz_ff [Steps+1][3];
   logic               cf_ff [Steps+1][3];
   logic               cv_ff [Steps+1];

   // Fold stage: half angle in Q.14, folded into plus or minus pi/2.
   logic signed [27:0] z0_in [3];
   logic               f0_in [3];
   logic signed [16:0] ang [3];

   assign ang[0] = 17'(req_data.yaw_angle);
   assign ang[1] = 17'(req_data.pitch_angle);
   assign ang[2] = 17'(req_data.roll_angle);

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         logic signed [16:0] h;
         h = ang[a];
         f0_in[a] = 1'b0;
         if (ang[a] > e2q_pkg::HalfPiQ14) begin
            h = ang[a] - e2q_pkg::PiQ14;
            f0_in[a] = 1'b1;
         end else if (ang[a] < -e2q_pkg::HalfPiQ14) begin
            h = ang[a] + e2q_pkg::PiQ14;
            f0_in[a] = 1'b1;
         end
         z0_in[a] = 28'(h) <<< 10;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cv_ff[0] <= 1'b0;
      end else if (adv) begin
         cv_ff[0] <= req_valid;
      end
      if (adv) begin
         for (int a = 0; a < 3; a++) begin
            cx_ff[0][a] <= e2q_pkg::CordicGainQ24;
            cy_ff[0][a] <= '0;
         end
         cz_ff[0] <= z0_in;
         cf_ff[0] <= f0_in;
      end
   end

   // CORDIC stages: stage i performs rotation i for all three angles.
   for (genvar i = 0; i < Steps; i++) begin : g_cordic
      logic signed [27:0] x_in [3];
      logic signed [27:0] y_in [3];
      logic signed [27:0] z_in [3];
      always_comb begin
         for (int a = 0; a < 3; a++) begin
            if (!cz_ff[i][a][27]) begin
               x_in[a] = cx_ff[i][a] - (cy_ff[i][a] >>> i);
               y_in[a] = cy_ff[i][a] + (cx_ff[i][a] >>> i);
               z_in[a] = cz_ff[i][a] - e2q_pkg::atan_q24(5'(i));
            end else begin
               x_in[a] = cx_ff[i][a] + (cy_ff[i][a] >>> i);
               y_in[a] = cy_ff[i][a] - (cx_ff[i][a] >>> i);
               z_in[a] = cz_ff[i][a] + e2q_pkg::atan_q24(5'(i));
            end
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            cv_ff[i+1] <= 1'b0;
         end else if (adv) begin
            cv_ff[i+1] <= cv_ff[i];
         end
         if (adv) begin
            cx_ff[i+1] <= x_in;
            cy_ff[i+1] <= y_in;
            cz_ff[i+1] <= z_in;
            cf_ff[i+1] <= cf_ff[i];
         end
      end
   end

   // Rounding stage: apply the fold sign and round to Q.15.
   logic signed [17:0] c_ff [3];
   logic signed [17:0] s_ff [3];
   logic signed [17:0] c_in [3];
   logic signed [17:0] s_in [3];
   logic               vr_ff;

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         logic signed [28:0] xc;
         logic signed [28:0] ys;
         xc = cf_ff[Steps][a] ? -29'(cx_ff[Steps][a]) : 29'(cx_ff[Steps][a]);
         ys = cf_ff[Steps][a] ? -29'(cy_ff[Steps][a]) : 29'(cy_ff[Steps][a]);
         c_in[a] = 18'((xc + 29'sd256) >>> 9);
         s_in[a] = 18'((ys + 29'sd256) >>> 9);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vr_ff <= 1'b0;
      end else if (adv) begin
         vr_ff <= cv_ff[Steps];
      end
      if (adv) begin
         c_ff <= c_in;
         s_ff <= s_in;
      end
   end

   // Product stage one: pairs of roll and pitch terms (index 0 yaw, 2 roll).
   logic signed [35:0] rp_ff [4]; // cr*cp, sr*sp, sr*cp, cr*sp
   logic signed [17:0] cyp_ff;
   logic signed [17:0] syp_ff;
   logic               vp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vp_ff <= 1'b0;
      end else if (adv) begin
         vp_ff <= vr_ff;
      end
      if (adv) begin
         rp_ff[0] <= c_ff[2] * c_ff[1];
         rp_ff[1] <= s_ff[2] * s_ff[1];
         rp_ff[2] <= s_ff[2] * c_ff[1];
         rp_ff[3] <= c_ff[2] * s_ff[1];
         cyp_ff   <= c_ff[0];
         syp_ff   <= s_ff[0];
      end
   end

   // Product stage two: multiply by yaw cosine and sine.
   logic signed [53:0] t_ff [8];
   logic               vt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vt_ff <= 1'b0;
      end else if (adv) begin
         vt_ff <= vp_ff;
      end
      if (adv) begin
         t_ff[0] <= rp_ff[0] * cyp_ff;
         t_ff[1] <= rp_ff[1] * syp_ff;
         t_ff[2] <= rp_ff[2] * cyp_ff;
         t_ff[3] <= rp_ff[3] * syp_ff;
         t_ff[4] <= rp_ff[3] * cyp_ff;
         t_ff[5] <= rp_ff[2] * syp_ff;
         t_ff[6] <= rp_ff[0] * syp_ff;
         t_ff[7] <= rp_ff[1] * cyp_ff;
      end
   end

   // Sum stage: combine, round to Q.14 and saturate.
   function automatic logic signed [15:0] to_q14(input logic signed [54:0] v);
      logic signed [54:0] r;
      r = (v + (55'sd1 <<< 30)) >>> 31;
      if (r > 55'(e2q_pkg::Q14One)) begin
         return e2q_pkg::Q14One;
      end else if (r < -55'(e2q_pkg::Q14One)) begin
         return -e2q_pkg::Q14One;
      end
      return 16'(r);
   endfunction

   e2q_pkg::rsp_type rsp_in;
   e2q_pkg::rsp_type rsp_ff;
   logic             vo_ff;

   always_comb begin
      rsp_in.quat_w = to_q14(55'(t_ff[0]) + 55'(t_ff[1]));
      rsp_in.quat_x = to_q14(55'(t_ff[2]) - 55'(t_ff[3]));
      rsp_in.quat_y = to_q14(55'(t_ff[4]) + 55'(t_ff[5]));
      rsp_in.quat_z = to_q14(55'(t_ff[6]) - 55'(t_ff[7]));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vo_ff <= 1'b0;
      end else if (adv) begin
         vo_ff <= vt_ff;
      end
      if (adv) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = vo_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   // A stalled result must still be offered on the next cycle.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result lost while stalled");
   // The input is refused exactly when a held result blocks the output.
   a_back: assert property (@(posedge clock) disable iff (reset)
      req_stall == (rsp_valid && rsp_stall))
      else $error("input stall does not follow output");
   // The w and z components stay within plus or minus one.
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.quat_w <= 16'sd16384 && rsp_data.quat_w >= -16'sd16384
                  && rsp_data.quat_z <= 16'sd16384 && rsp_data.quat_z >= -16'sd16384))
      else $error("component out of range");
`endif

endmodule
